// File: rtl/hdsc_pkg.sv
`default_nettype none

package hdsc_pkg;

  localparam int SINE_ENTRIES = 360;
  localparam int SINE_AW      = $clog2(SINE_ENTRIES);
  localparam int ELEC_MAX     = SINE_ENTRIES * 4 - 1;

  // mech = elec*360/1439 through a reciprocal, exact for elec*360 below 2^19
  localparam int          MECH_SHIFT  = 30;
  localparam logic [63:0] MECH_RECIP_W =
    ((64'd1 << MECH_SHIFT) + 64'(ELEC_MAX) - 64'd1) / 64'(ELEC_MAX);
  localparam logic [19:0] MECH_RECIP  = MECH_RECIP_W[19:0];

  localparam logic [11:0] OFFSET_RESET    = 12'd860;
  localparam logic [8:0]  THRESHOLD_RESET = 9'd50;
  localparam logic [8:0]  WINDOW_RESET    = 9'd10;
  localparam logic [7:0]  GAIN_RESET      = 8'd10;
  localparam logic [8:0]  DEADBAND_RESET  = 9'd2;
  localparam logic [15:0] TARGET_RESET    = 16'd80;

  localparam logic [8:0]  ADVANCE_NEG = 9'd90;
  localparam logic [8:0]  ADVANCE_POS = 9'd270;
  localparam logic [9:0]  DUTY_MID    = 10'd511;
  localparam logic [9:0]  SINE_MID    = 10'd512;

  // register indexes on the configuration port (word address)
  localparam logic [2:0] REG_ANGLE_OFFSET   = 3'd0;
  localparam logic [2:0] REG_TURN_THRESHOLD = 3'd1;
  localparam logic [2:0] REG_DRAG_WINDOW    = 3'd2;
  localparam logic [2:0] REG_TORQUE_GAIN    = 3'd3;
  localparam logic [2:0] REG_DEADBAND       = 3'd4;

  typedef enum logic [1:0] {
    SM_TURN,
    SM_TARGET,
    SM_PREV
  } smem_addr_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ELEC1,
    ST_ELEC2,
    ST_MECH1,
    ST_MECH2,
    ST_TURN,
    ST_POS,
    ST_ERR,
    ST_EVAL,
    ST_TORQ,
    ST_TSAT,
    ST_DIVQ,
    ST_DIVD,
    ST_ROMC,
    ST_DIV,
    ST_FINISH
  } state_t;

  localparam logic [9:0] SINE_LUT [SINE_ENTRIES] = '{
    10'd512, 10'd521, 10'd530, 10'd539, 10'd548, 10'd557, 10'd565, 10'd574, 10'd583, 10'd592,
    10'd601, 10'd610, 10'd618, 10'd627, 10'd636, 10'd644, 10'd653, 10'd661, 10'd670, 10'd678,
    10'd687, 10'd695, 10'd703, 10'd712, 10'd720, 10'd728, 10'd736, 10'd744, 10'd752, 10'd760,
    10'd768, 10'd775, 10'd783, 10'd790, 10'd798, 10'd805, 10'd812, 10'd820, 10'd827, 10'd834,
    10'd840, 10'd847, 10'd854, 10'd861, 10'd867, 10'd873, 10'd880, 10'd886, 10'd892, 10'd898,
    10'd903, 10'd909, 10'd915, 10'd920, 10'd925, 10'd931, 10'd936, 10'd941, 10'd945, 10'd950,
    10'd955, 10'd959, 10'd963, 10'd967, 10'd971, 10'd975, 10'd979, 10'd982, 10'd986, 10'd989,
    10'd992, 10'd995, 10'd998, 10'd1001, 10'd1003, 10'd1006, 10'd1008, 10'd1010, 10'd1012,
    10'd1014,
    10'd1015, 10'd1017, 10'd1018, 10'd1019, 10'd1020, 10'd1021, 10'd1022, 10'd1022, 10'd1023,
    10'd1023,
    10'd1023, 10'd1023, 10'd1023, 10'd1022, 10'd1022, 10'd1021, 10'd1020, 10'd1019, 10'd1018,
    10'd1017,
    10'd1015, 10'd1014, 10'd1012, 10'd1010, 10'd1008, 10'd1006, 10'd1003, 10'd1001, 10'd998,
    10'd995,
    10'd992, 10'd989, 10'd986, 10'd982, 10'd979, 10'd975, 10'd971, 10'd967, 10'd963, 10'd959,
    10'd955, 10'd950, 10'd945, 10'd941, 10'd936, 10'd931, 10'd925, 10'd920, 10'd915, 10'd909,
    10'd903, 10'd898, 10'd892, 10'd886, 10'd880, 10'd873, 10'd867, 10'd861, 10'd854, 10'd847,
    10'd840, 10'd834, 10'd827, 10'd820, 10'd812, 10'd805, 10'd798, 10'd790, 10'd783, 10'd775,
    10'd768, 10'd760, 10'd752, 10'd744, 10'd736, 10'd728, 10'd720, 10'd712, 10'd703, 10'd695,
    10'd687, 10'd678, 10'd670, 10'd661, 10'd653, 10'd644, 10'd636, 10'd627, 10'd618, 10'd610,
    10'd601, 10'd592, 10'd583, 10'd574, 10'd565, 10'd557, 10'd548, 10'd539, 10'd530, 10'd521,
    10'd512, 10'd503, 10'd494, 10'd485, 10'd476, 10'd467, 10'd459, 10'd450, 10'd441, 10'd432,
    10'd423, 10'd414, 10'd406, 10'd397, 10'd388, 10'd380, 10'd371, 10'd363, 10'd354, 10'd346,
    10'd337, 10'd329, 10'd321, 10'd312, 10'd304, 10'd296, 10'd288, 10'd280, 10'd272, 10'd264,
    10'd257, 10'd249, 10'd241, 10'd234, 10'd226, 10'd219, 10'd212, 10'd204, 10'd197, 10'd190,
    10'd184, 10'd177, 10'd170, 10'd163, 10'd157, 10'd151, 10'd144, 10'd138, 10'd132, 10'd126,
    10'd121, 10'd115, 10'd109, 10'd104, 10'd99, 10'd93, 10'd88, 10'd83, 10'd79, 10'd74,
    10'd69, 10'd65, 10'd61, 10'd57, 10'd53, 10'd49, 10'd45, 10'd42, 10'd38, 10'd35,
    10'd32, 10'd29, 10'd26, 10'd23, 10'd21, 10'd18, 10'd16, 10'd14, 10'd12, 10'd10,
    10'd9, 10'd7, 10'd6, 10'd5, 10'd4, 10'd3, 10'd2, 10'd2, 10'd1, 10'd1,
    10'd1, 10'd1, 10'd1, 10'd2, 10'd2, 10'd3, 10'd4, 10'd5, 10'd6, 10'd7,
    10'd9, 10'd10, 10'd12, 10'd14, 10'd16, 10'd18, 10'd21, 10'd23, 10'd26, 10'd29,
    10'd32, 10'd35, 10'd38, 10'd42, 10'd45, 10'd49, 10'd53, 10'd57, 10'd61, 10'd65,
    10'd69, 10'd74, 10'd79, 10'd83, 10'd88, 10'd93, 10'd99, 10'd104, 10'd109, 10'd115,
    10'd121, 10'd126, 10'd132, 10'd138, 10'd144, 10'd151, 10'd157, 10'd163, 10'd170, 10'd177,
    10'd184, 10'd190, 10'd197, 10'd204, 10'd212, 10'd219, 10'd226, 10'd234, 10'd241, 10'd249,
    10'd257, 10'd264, 10'd272, 10'd280, 10'd288, 10'd296, 10'd304, 10'd312, 10'd321, 10'd329,
    10'd337, 10'd346, 10'd354, 10'd363, 10'd371, 10'd380, 10'd388, 10'd397, 10'd406, 10'd414,
    10'd423, 10'd432, 10'd441, 10'd450, 10'd459, 10'd467, 10'd476, 10'd485, 10'd494, 10'd503
  };

  // upper half of a remainder by 360: strips 360*128 down to 360*16
  function automatic logic [16:0] mod360_hi(input logic [16:0] x);
    logic [16:0] v;
    v = x;
    for (int k = 7; k >= 4; k--) begin
      if (v >= (17'd360 << k)) v = v - (17'd360 << k);
    end
    return v;
  endfunction

  // lower half: strips 360*8 down to 360, leaves 0..359
  function automatic logic [16:0] mod360_lo(input logic [16:0] x);
    logic [16:0] v;
    v = x;
    for (int k = 3; k >= 0; k--) begin
      if (v >= (17'd360 << k)) v = v - (17'd360 << k);
    end
    return v;
  endfunction

  // electrical angle plus advance, below 2160, reduced to 0..359
  function automatic logic [8:0] drive_mod(input logic [11:0] x);
    logic [11:0] v;
    v = x;
    if (v >= 12'd1440) v = v - 12'd1440;
    if (v >= 12'd720) v = v - 12'd720;
    if (v >= 12'd360) v = v - 12'd360;
    return v[8:0];
  endfunction

  function automatic logic [8:0] phase_shift(input logic [8:0] ang, input logic [8:0] ofs);
    logic [9:0] v;
    v = {1'b0, ang} + {1'b0, ofs};
    if (v >= 10'd360) v = v - 10'd360;
    return v[8:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/haptic_detent_sine_commutator.sv
`default_nettype none

// channel  direction  transfer when            payload
// in_      input      in_valid & !in_stall     in_encoder_angle
// out_     output     out_valid & !out_stall   phase a/b/c duty, torque, offset, drive angle
// cfg      apb        psel & penable & pwrite  five registers at paddr 0x00..0x10
//
// one item at a time: the input stalls while the sequencer is busy, and the next
// item is taken once the result has been loaded into the output register
// the sequencer walks a state memory with one read and one write port and
// one sine rom port, then nine steps of three radix-2 divider lanes
// rst_n (synchronous) resets the registers to their defaults and marks the
// state memory empty; empty entries read as turn 0, target 80, no previous angle
// a stalled result holds in the output register; a new item is taken meanwhile,
// and the sequencer waits in its last state until the register frees up

module haptic_detent_sine_commutator
  import hdsc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [11:0] in_encoder_angle,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [9:0]       out_phase_a_duty,
  output logic [9:0]       out_phase_b_duty,
  output logic [9:0]       out_phase_c_duty,
  output logic [7:0]       out_torque_level,
  output logic [11:0]      out_offset_angle,
  output logic [8:0]       out_drive_angle,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  state_t state_r, state_nxt;

  // configuration registers
  logic [11:0] ofs_r;
  logic [8:0]  thr_r;
  logic [8:0]  dw_r;
  logic [7:0]  gain_r;
  logic [8:0]  db_r;

  // state memory: turn count, target position, previous mechanical angle
  logic [15:0] smem [3];
  logic [2:0]  smem_vld_r;
  smem_addr_t  smem_raddr;
  smem_addr_t  smem_waddr;
  logic        smem_we;
  logic [15:0] smem_wdata;
  logic [15:0] smem_q_r;
  logic        smem_qvld_r;
  smem_addr_t  smem_qaddr_r;
  logic [15:0] smem_rd;

  // sine rom read port
  logic [SINE_AW-1:0] rom_addr;
  logic [9:0]         rom_q_r;

  // datapath
  logic [11:0] off_r;
  logic [22:0] elp_r;
  logic [10:0] elec_r;
  logic [18:0] ex_r;
  logic [8:0]  mech_r;
  logic [8:0]  prev_r;
  logic        first_r;
  logic [15:0] turn_r;
  logic [15:0] tgt_r;
  logic [15:0] pm_r;
  logic [15:0] err_r;
  logic [15:0] aerr_r;
  logic        neg_r;
  logic        drag_r;
  logic [17:0] dsum_r;
  logic [16:0] dmag_r;
  logic [8:0]  drv_r;
  logic [23:0] tqm_r;
  logic [7:0]  torque_r;
  logic [15:0] t249_r;
  logic [7:0]  div_d_r;
  logic [9:0]  s_a_r;
  logic [9:0]  s_b_r;
  logic [3:0]  div_cnt_r;
  logic [8:0]  quo_r [3];
  logic [7:0]  rem_r [3];
  logic [2:0]  above_r;

  // output register
  logic        out_valid_r;
  logic [9:0]  out_a_r;
  logic [9:0]  out_b_r;
  logic [9:0]  out_c_r;
  logic [7:0]  out_tq_r;
  logic [11:0] out_off_r;
  logic [8:0]  out_drv_r;

  logic        in_xfer;
  logic        out_free;
  logic        cfg_wr;

  // combinational helpers
  logic [12:0] elec_sum;
  logic [38:0] mech_prod;
  logic [8:0]  jump;
  logic [15:0] turn_nxt;
  logic [15:0] aerr_c;
  logic [17:0] dsum_c;
  logic [7:0]  tq_sat;
  logic [8:0]  dq_sum;
  logic [7:0]  dq;
  logic [17:0] dneg_fix;
  logic [15:0] tgt_new;
  logic [9:0]  s_ld [3];
  logic [9:0]  duty [3];

  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign in_stall = (state_r != ST_IDLE);
  assign pready   = 1'b1;

  // ---------------- configuration port ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ofs_r  <= OFFSET_RESET;
      thr_r  <= THRESHOLD_RESET;
      dw_r   <= WINDOW_RESET;
      gain_r <= GAIN_RESET;
      db_r   <= DEADBAND_RESET;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_ANGLE_OFFSET:   ofs_r  <= pwdata[11:0];
        REG_TURN_THRESHOLD: thr_r  <= pwdata[8:0];
        REG_DRAG_WINDOW:    dw_r   <= pwdata[8:0];
        REG_TORQUE_GAIN:    gain_r <= pwdata[7:0];
        REG_DEADBAND:       db_r   <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_ANGLE_OFFSET:   prdata = {20'd0, ofs_r};
      REG_TURN_THRESHOLD: prdata = {23'd0, thr_r};
      REG_DRAG_WINDOW:    prdata = {23'd0, dw_r};
      REG_TORQUE_GAIN:    prdata = {24'd0, gain_r};
      REG_DEADBAND:       prdata = {23'd0, db_r};
      default:            prdata = 32'd0;
    endcase
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    smem_raddr = SM_PREV;
    smem_waddr = SM_TURN;
    smem_we    = 1'b0;
    smem_wdata = turn_nxt;
    rom_addr   = drv_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) state_nxt = ST_ELEC1;
      end
      ST_ELEC1: begin
        smem_raddr = SM_TURN;
        state_nxt  = ST_ELEC2;
      end
      ST_ELEC2: begin
        smem_raddr = SM_TARGET;
        state_nxt  = ST_MECH1;
      end
      ST_MECH1: state_nxt = ST_MECH2;
      ST_MECH2: state_nxt = ST_TURN;
      ST_TURN: begin
        smem_we    = 1'b1;
        smem_waddr = SM_TURN;
        smem_wdata = turn_nxt;
        state_nxt  = ST_POS;
      end
      ST_POS: begin
        // writing the previous angle also marks the first sample as seen
        smem_we    = 1'b1;
        smem_waddr = SM_PREV;
        smem_wdata = {7'd0, mech_r};
        state_nxt  = ST_ERR;
      end
      ST_ERR:  state_nxt = ST_EVAL;
      ST_EVAL: state_nxt = ST_TORQ;
      ST_TORQ: state_nxt = ST_TSAT;
      ST_TSAT: begin
        rom_addr  = drv_r;
        state_nxt = ST_DIVQ;
      end
      ST_DIVQ: begin
        smem_we    = drag_r;
        smem_waddr = SM_TARGET;
        smem_wdata = tgt_new;
        rom_addr   = phase_shift(drv_r, 9'd120);
        state_nxt  = ST_DIVD;
      end
      ST_DIVD: begin
        rom_addr  = phase_shift(drv_r, 9'd240);
        state_nxt = ST_ROMC;
      end
      ST_ROMC: state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_cnt_r == 4'd8) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------- state memory ----------------
  always_ff @(posedge clk) begin
    if (smem_we) smem[smem_waddr] <= smem_wdata;
    smem_q_r     <= smem[smem_raddr];
    smem_qaddr_r <= smem_raddr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smem_vld_r  <= 3'b000;
      smem_qvld_r <= 1'b0;
    end else begin
      if (smem_we) smem_vld_r[smem_waddr] <= 1'b1;
      smem_qvld_r <= smem_vld_r[smem_raddr];
    end
  end

  // an entry never written reads as its reset value
  always_comb begin
    if (smem_qvld_r) begin
      smem_rd = smem_q_r;
    end else begin
      unique case (smem_qaddr_r)
        SM_TARGET: smem_rd = TARGET_RESET;
        default:   smem_rd = 16'd0;
      endcase
    end
  end

  // ---------------- sine rom ----------------
  always_ff @(posedge clk) begin
    rom_q_r <= SINE_LUT[rom_addr];
  end

  // ---------------- datapath ----------------
  // off*1439 = a*4096 + b = a*4095 + (a + b), and a + b stays below 2*4095
  assign elec_sum  = {2'd0, elp_r[22:12]} + {1'b0, elp_r[11:0]};
  assign mech_prod = 39'(ex_r) * 39'(MECH_RECIP);

  assign jump = (prev_r > mech_r) ? (prev_r - mech_r) : (mech_r - prev_r);

  always_comb begin
    turn_nxt = turn_r;
    if (first_r && (jump > thr_r)) begin
      if (prev_r > mech_r) turn_nxt = turn_r + 16'd1;
      else turn_nxt = turn_r - 16'd1;
    end
  end

  assign aerr_c = err_r[15] ? (16'd0 - err_r) : err_r;
  assign dsum_c = err_r[15] ?
    ({{2{tgt_r[15]}}, tgt_r} + {{2{err_r[15]}}, err_r} + {9'd0, dw_r}) :
    ({{2{tgt_r[15]}}, tgt_r} + {{2{err_r[15]}}, err_r} - {9'd0, dw_r});

  assign tq_sat = (tqm_r > 24'd255) ? 8'd255 : tqm_r[7:0];

  // torque*249/255: t = a*256 + b = a*255 + (a + b), and a + b stays below 2*255
  assign dq_sum = {1'b0, t249_r[15:8]} + {1'b0, t249_r[7:0]};
  assign dq     = t249_r[15:8] + ((dq_sum >= 9'd255) ? 8'd1 : 8'd0);

  assign dneg_fix = dsum_r[17] ? (dsum_r + 18'd360) : dsum_r;

  // non-negative error: remainder takes the sign of the sum
  always_comb begin
    if (neg_r) begin
      tgt_new = dneg_fix[15:0];
    end else if (dsum_r[17]) begin
      tgt_new = 16'd0 - dmag_r[15:0];
    end else begin
      tgt_new = dmag_r[15:0];
    end
  end

  assign s_ld[0] = s_a_r;
  assign s_ld[1] = s_b_r;
  assign s_ld[2] = rom_q_r;

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) off_r <= in_encoder_angle + ofs_r;
      end
      ST_ELEC1: begin
        prev_r  <= smem_rd[8:0];
        first_r <= smem_qvld_r;
        elp_r   <= 23'(off_r) * 23'd1439;
      end
      ST_ELEC2: begin
        elec_r <= elp_r[22:12] + ((elec_sum >= 13'd4095) ? 11'd1 : 11'd0);
        turn_r <= smem_rd;
      end
      ST_MECH1: begin
        ex_r  <= 19'(elec_r) * 19'd360;
        tgt_r <= smem_rd;
      end
      ST_MECH2: mech_r <= mech_prod[MECH_SHIFT +: 9];
      ST_TURN:  turn_r <= turn_nxt;
      ST_POS:   pm_r <= 16'(32'(turn_r) * 32'd360);
      ST_ERR:   err_r <= pm_r + {7'd0, mech_r} - tgt_r;
      ST_EVAL: begin
        aerr_r <= aerr_c;
        neg_r  <= err_r[15];
        drag_r <= (aerr_c > {7'd0, dw_r});
        dsum_r <= dsum_c;
        drv_r  <= drive_mod({1'b0, elec_r} + {3'd0, (err_r[15] ? ADVANCE_NEG : ADVANCE_POS)});
      end
      ST_TORQ: begin
        tqm_r  <= 24'(aerr_r) * 24'(gain_r);
        dmag_r <= mod360_hi(dsum_r[17] ? 17'(18'd0 - dsum_r) : dsum_r[16:0]);
      end
      ST_TSAT: begin
        torque_r <= (aerr_r < {7'd0, db_r}) ? 8'd0 : tq_sat;
        dmag_r   <= mod360_lo(dmag_r);
      end
      ST_DIVQ: begin
        t249_r <= 16'(torque_r) * 16'd249;
        s_a_r  <= rom_q_r;
      end
      ST_DIVD: begin
        div_d_r <= 8'd255 - dq;
        s_b_r   <= rom_q_r;
      end
      ST_ROMC: begin
        div_cnt_r <= 4'd0;
        for (int i = 0; i < 3; i++) begin
          above_r[i] <= (s_ld[i] > SINE_MID);
          quo_r[i]   <= (s_ld[i] > SINE_MID) ? 9'(s_ld[i] - SINE_MID) : 9'(SINE_MID - s_ld[i]);
          rem_r[i]   <= 8'd0;
        end
      end
      ST_DIV: begin
        div_cnt_r <= div_cnt_r + 4'd1;
        for (int i = 0; i < 3; i++) begin
          if ({rem_r[i], quo_r[i][8]} >= {1'b0, div_d_r}) begin
            rem_r[i] <= 8'({rem_r[i], quo_r[i][8]} - {1'b0, div_d_r});
            quo_r[i] <= {quo_r[i][7:0], 1'b1};
          end else begin
            rem_r[i] <= {rem_r[i][6:0], quo_r[i][8]};
            quo_r[i] <= {quo_r[i][7:0], 1'b0};
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      duty[i] = above_r[i] ? (DUTY_MID + {1'b0, quo_r[i]}) : (DUTY_MID - {1'b0, quo_r[i]});
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_FINISH && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FINISH && out_free) begin
      out_a_r   <= duty[0];
      out_b_r   <= duty[1];
      out_c_r   <= duty[2];
      out_tq_r  <= torque_r;
      out_off_r <= off_r;
      out_drv_r <= drv_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_phase_a_duty = out_a_r;
  assign out_phase_b_duty = out_b_r;
  assign out_phase_c_duty = out_c_r;
  assign out_torque_level = out_tq_r;
  assign out_offset_angle = out_off_r;
  assign out_drive_angle  = out_drv_r;

  // ---------------- assertions ----------------
  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_drive_angle < 9'd360)
    else $error("drive angle out of range");

  a_divisor_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> div_d_r >= 8'd6)
    else $error("divisor below six");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !smem_we)
    else $error("state memory written while idle");

  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH))
    else $error("result loaded outside the last step");

  a_deadband: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIVQ && aerr_r < {7'd0, db_r}) |-> torque_r == 8'd0)
    else $error("torque inside deadband");

endmodule

`default_nettype wire

// File: dv/tb_haptic_detent_sine_commutator.sv
`timescale 1ns / 1ps

module tb_haptic_detent_sine_commutator;
  import hdsc_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_PER_SETTING = 215;
  localparam int SETTING_COUNT = 6;
  // an index past the last register, writes there must be ignored
  localparam logic [2:0] REG_UNMAPPED = 3'd7;

  localparam logic [11:0] DIRECTED_ANGLES [22] = '{
    12'd0, 12'd4095, 12'd3236, 12'd3235, 12'd2048, 12'd2048, 12'd2618, 12'd3188,
    12'd3758, 12'd232, 12'd802, 12'd232, 12'd3758, 12'd3188, 12'd1, 12'd4094,
    12'd1024, 12'd3072, 12'd2047, 12'd2049, 12'd4095, 12'd0
  };

  typedef struct packed {
    logic [9:0]  phase_a_duty;
    logic [9:0]  phase_b_duty;
    logic [9:0]  phase_c_duty;
    logic [7:0]  torque_level;
    logic [11:0] offset_angle;
    logic [8:0]  drive_angle;
  } commutation_t;

  class commutator_scoreboard;
    int angle_offset, turn_threshold, drag_window, torque_gain, deadband;
    int prev_mech, turn_count, target_pos;
    bit seen_sample;
    commutation_t expected_q[$];
    int errors, checked, peak_turns;

    function new();
      angle_offset = 860;
      turn_threshold = 50;
      drag_window = 10;
      torque_gain = 10;
      deadband = 2;
      prev_mech = 0;
      seen_sample = 0;
      turn_count = 0;
      target_pos = 80;
      errors = 0;
      checked = 0;
      peak_turns = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
        REG_ANGLE_OFFSET:   angle_offset = int'(value[11:0]);
        REG_TURN_THRESHOLD: turn_threshold = int'(value[8:0]);
        REG_DRAG_WINDOW:    drag_window = int'(value[8:0]);
        REG_TORQUE_GAIN:    torque_gain = int'(value[7:0]);
        REG_DEADBAND:       deadband = int'(value[8:0]);
        default: ;
      endcase
    endfunction

    function int wrap16(int v);
      logic [15:0] u;
      u = v[15:0];
      return int'($signed(u));
    endfunction

    function int duty(int ang, int divisor);
      int s;
      s = int'(SINE_LUT[ang]);
      if (s > 512) return 511 + (s - 512) / divisor;
      return 511 - (512 - s) / divisor;
    endfunction

    function void note_sample(logic [11:0] raw);
      int off, elec, mech, jump, turns, pos, tgt, err, aerr, nt;
      int prod, torque, advance, drive, divisor;
      commutation_t r;
      off = (int'(raw) + angle_offset) % 4096;
      elec = off * 1439 / 4095;
      mech = elec * 360 / 1439;
      jump = prev_mech > mech ? prev_mech - mech : mech - prev_mech;
      // the first sample after reset never counts a turn
      if (seen_sample && jump > turn_threshold) begin
        if (prev_mech > mech) turn_count = (turn_count + 1) & 16'hFFFF;
        else turn_count = (turn_count - 1) & 16'hFFFF;
      end
      seen_sample = 1;
      prev_mech = mech;

      turns = wrap16(turn_count);
      if (turns > peak_turns) peak_turns = turns;
      if (-turns > peak_turns) peak_turns = -turns;
      pos = wrap16(turns * 360 + mech);
      tgt = wrap16(target_pos);
      err = wrap16(pos - tgt);
      aerr = err < 0 ? -err : err;

      if (err < 0) begin
        advance = 90;
        if (aerr > drag_window) begin
          nt = tgt + err + drag_window;
          if (nt < 0) nt += 360;
          target_pos = nt & 16'hFFFF;
        end
      end else begin
        advance = 270;
        if (aerr > drag_window) begin
          // truncating remainder keeps the sign of the sum
          nt = (tgt + err - drag_window) % 360;
          target_pos = nt & 16'hFFFF;
        end
      end

      prod = aerr * torque_gain;
      torque = prod > 255 ? 255 : prod;
      if (aerr < deadband) torque = 0;
      divisor = 255 - torque * 249 / 255;
      drive = (elec + advance) % SINE_ENTRIES;

      r.phase_a_duty = 10'(duty(drive, divisor));
      r.phase_b_duty = 10'(duty((drive + 120) % SINE_ENTRIES, divisor));
      r.phase_c_duty = 10'(duty((drive + 240) % SINE_ENTRIES, divisor));
      r.torque_level = 8'(torque);
      r.offset_angle = 12'(off);
      r.drive_angle = 9'(drive);
      expected_q.push_back(r);
    endfunction

    function void compare(string field, int want, int got);
      if (want != got) begin
        $display("%t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(commutation_t got);
      commutation_t want;
      if (expected_q.size() == 0) begin
        $display("%t: result with no sample pending, expected none actual drive angle %0d",
                 $time, got.drive_angle);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      compare("phase_a_duty", want.phase_a_duty, got.phase_a_duty);
      compare("phase_b_duty", want.phase_b_duty, got.phase_b_duty);
      compare("phase_c_duty", want.phase_c_duty, got.phase_c_duty);
      compare("torque_level", want.torque_level, got.torque_level);
      compare("offset_angle", want.offset_angle, got.offset_angle);
      compare("drive_angle", want.drive_angle, got.drive_angle);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [11:0] in_encoder_angle = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [9:0]  out_phase_a_duty, out_phase_b_duty, out_phase_c_duty;
  logic [7:0]  out_torque_level;
  logic [11:0] out_offset_angle;
  logic [8:0]  out_drive_angle;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  commutator_scoreboard sb;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int idle_cycles = 0;
  int samples_sent = 0;
  int settings_used = 0;
  int walk_angle = 0;

  haptic_detent_sine_commutator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_encoder_angle (in_encoder_angle),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_phase_a_duty (out_phase_a_duty),
    .out_phase_b_duty (out_phase_b_duty),
    .out_phase_c_duty (out_phase_c_duty),
    .out_torque_level (out_torque_level),
    .out_offset_angle (out_offset_angle),
    .out_drive_angle  (out_drive_angle),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // results are checked before the same-edge input is noted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        sb.check_result(commutation_t'({out_phase_a_duty, out_phase_b_duty, out_phase_c_duty,
                                        out_torque_level, out_offset_angle,
                                        out_drive_angle}));
      if (in_valid && !in_stall) sb.note_sample(in_encoder_angle);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable && pready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%t: no transfer for %0d cycles, %0d results outstanding",
               $time, idle_cycles, sb.pending());
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_angle(input logic [11:0] angle);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_encoder_angle <= angle;
    do @(posedge clk); while (in_stall);
    samples_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // leaves psel high so that writes can follow back to back
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, value);
  endtask

  task automatic release_bus();
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // upper data bits carry noise, only the register width counts
  task automatic apply_settings(input int offset, input int threshold, input int window,
                                input int gain, input int band);
    write_reg(REG_ANGLE_OFFSET, ($urandom & 32'hFFFF_F000) | 32'(offset));
    write_reg(REG_TURN_THRESHOLD, ($urandom & 32'hFFFF_FE00) | 32'(threshold));
    write_reg(REG_DRAG_WINDOW, ($urandom & 32'hFFFF_FE00) | 32'(window));
    write_reg(REG_TORQUE_GAIN, ($urandom & 32'hFFFF_FF00) | 32'(gain));
    write_reg(REG_DEADBAND, ($urandom & 32'hFFFF_FE00) | 32'(band));
    release_bus();
    settings_used++;
  endtask

  // mostly a rotor that turns: smooth walks and steady spins, some noise
  task automatic run_random(input int total);
    int sent, len, style, step;
    sent = 0;
    while (sent < total) begin
      style = $urandom_range(9);
      if (style < 3) begin
        len = $urandom_range(60, 150);
        step = $urandom_range(500, 2000);
        if ($urandom_range(1)) step = -step;
      end else begin
        len = $urandom_range(10, 50);
        step = 0;
      end
      for (int i = 0; i < len && sent < total; i++) begin
        if (style < 3) walk_angle = walk_angle + step;
        else if (style < 8) walk_angle = walk_angle + int'($urandom_range(400)) - 200;
        else walk_angle = int'($urandom_range(4095));
        walk_angle = walk_angle & 4095;
        send_angle(walk_angle[11:0]);
        sent++;
      end
      if ($urandom_range(7) == 0) drain_results();
    end
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // stray write past the register file, then the reset settings
    write_reg(REG_UNMAPPED, $urandom);
    release_bus();
    foreach (DIRECTED_ANGLES[i]) send_angle(DIRECTED_ANGLES[i]);
    drain_results();

    for (int k = 0; k < SETTING_COUNT; k++) begin
      case (k / 2)
        0: begin
          send_idle_pct = 38;
          recv_stall_pct = 85;
        end
        1: begin
          send_idle_pct = 85;
          recv_stall_pct = 38;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      case (k)
        0: apply_settings(0, 0, 0, 0, 0);
        1: apply_settings(4095, 511, 511, 255, 511);
        3: apply_settings($urandom_range(4095), 360, 360, 255, 0);
        default: apply_settings($urandom_range(4095), $urandom_range(511), $urandom_range(511),
                                $urandom_range(255), $urandom_range(511));
      endcase
      run_random(RANDOM_PER_SETTING);
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("%0d encoder samples under %0d register settings, %0d results compared",
             samples_sent, settings_used, sb.checked);
    $display("largest turn count magnitude %0d, %0d mismatches", sb.peak_turns, sb.errors);
    if (sb.pending() != 0) $display("%0d results never arrived", sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/hdsc_pkg.sv
rtl/haptic_detent_sine_commutator.sv
dv/tb_haptic_detent_sine_commutator.sv
